>>> rtl/ata_pkg.sv
// ----------------------------------------------------------------------------
// ata_pkg: shared types and constants for the tilt angle pipeline
// Payload structs, datapath widths, fixed-point atan2 constants, CSR codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ata_pkg;

   // Datapath widths
   localparam int AX_W       = 17;  // offset-corrected axis value
   localparam int SQ_W       = 34;  // sum of two squares
   localparam int RAD_W      = 50;  // square root radicand (sum << 16)
   localparam int ROOT_W     = 25;  // square root result
   localparam int SQRT_REM_W = 28;  // square root partial remainder
   localparam int SQRT_STEPS = 25;  // one root bit per cell
   localparam int ARG_W      = 26;  // signed atan2 argument (Q8)
   localparam int MAG_W      = 25;  // argument magnitude
   localparam int DIV_REM_W  = 27;  // divider partial remainder
   localparam int QUO_W      = 17;  // ratio in Q16, up to 1.0
   localparam int DIV_STEPS  = 17;  // one quotient bit per cell
   localparam int Z_W        = 20;  // signed angle in radians Q16
   localparam int ATAN_LAT   = 26;  // register stages inside one atan2 unit

   // Polynomial and quadrant constants (radians Q16)
   localparam logic [QUO_W-1:0] Q_ONE     = 17'd65536;
   localparam logic [15:0]      C_PI4     = 16'd51472;
   localparam logic [13:0]      C_K1      = 14'd16037;
   localparam logic [12:0]      C_K2      = 13'd4345;
   localparam logic signed [Z_W-1:0] C_PI2 = 20'sd102944;
   localparam logic signed [Z_W-1:0] C_PI  = 20'sd205887;
   localparam logic [21:0]      C_RAD2DEG = 22'd3754937;  // 180/pi in Q16

   // Register index codes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_X = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Y = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OFFSET_Z = 2'd2;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] roll_angle;
      logic signed [15:0] pitch_angle;
   } rsp_type;

endpackage

`default_nettype wire

>>> rtl/ata_sqrt_cell.sv
// ----------------------------------------------------------------------------
// ata_sqrt_cell: one cell of the square root chain
// Brings in two radicand bits, decides one root bit, passes on to the next cell.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_sqrt_cell (
   input  wire logic                             clock,
   input  wire logic                             en,
   input  wire logic [ata_pkg::RAD_W-1:0]        in_rad,
   input  wire logic [ata_pkg::SQRT_REM_W-1:0]   in_rem,
   input  wire logic [ata_pkg::ROOT_W-1:0]       in_root,
   output logic      [ata_pkg::RAD_W-1:0]        out_rad,
   output logic      [ata_pkg::SQRT_REM_W-1:0]   out_rem,
   output logic      [ata_pkg::ROOT_W-1:0]       out_root
);

   logic [ata_pkg::RAD_W-1:0]      rad_ff, rad_in;
   logic [ata_pkg::SQRT_REM_W-1:0] rem_ff, rem_in;
   logic [ata_pkg::ROOT_W-1:0]     root_ff, root_in;
   logic [ata_pkg::SQRT_REM_W-1:0] cur, trial;
   logic                           ge;

   // trial subtract of (4*root + 1)
   always_comb begin
      cur     = {in_rem[ata_pkg::SQRT_REM_W-3:0], in_rad[ata_pkg::RAD_W-1 -: 2]};
      trial   = {{(ata_pkg::SQRT_REM_W-ata_pkg::ROOT_W-2){1'b0}}, in_root, 2'b01};
      ge      = (cur >= trial);
      rem_in  = ge ? (cur - trial) : cur;
      root_in = {in_root[ata_pkg::ROOT_W-2:0], ge};
      rad_in  = {in_rad[ata_pkg::RAD_W-3:0], 2'b00};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
      end
   end

   assign out_rad  = rad_ff;
   assign out_rem  = rem_ff;
   assign out_root = root_ff;

endmodule

`default_nettype wire

>>> rtl/ata_div_cell.sv
// ----------------------------------------------------------------------------
// ata_div_cell: one cell of the restoring divider chain
// Decides one quotient bit and passes the shifted remainder on.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_div_cell (
   input  wire logic                            clock,
   input  wire logic                            en,
   input  wire logic [ata_pkg::DIV_REM_W-1:0]   in_rem,
   input  wire logic [ata_pkg::MAG_W-1:0]       in_den,
   input  wire logic [ata_pkg::QUO_W-1:0]       in_quo,
   output logic      [ata_pkg::DIV_REM_W-1:0]   out_rem,
   output logic      [ata_pkg::MAG_W-1:0]       out_den,
   output logic      [ata_pkg::QUO_W-1:0]       out_quo
);

   logic [ata_pkg::DIV_REM_W-1:0] rem_ff, rem_in;
   logic [ata_pkg::MAG_W-1:0]     den_ff;
   logic [ata_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [ata_pkg::DIV_REM_W-1:0] den_ext, diff;
   logic                          ge;

   // compare, subtract, shift
   always_comb begin
      den_ext = {{(ata_pkg::DIV_REM_W-ata_pkg::MAG_W){1'b0}}, in_den};
      ge      = (in_rem >= den_ext);
      diff    = ge ? (in_rem - den_ext) : in_rem;
      rem_in  = {diff[ata_pkg::DIV_REM_W-2:0], 1'b0};
      quo_in  = {in_quo[ata_pkg::QUO_W-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rem_ff <= rem_in;
         den_ff <= in_den;
         quo_ff <= quo_in;
      end
   end

   assign out_rem = rem_ff;
   assign out_den = den_ff;
   assign out_quo = quo_ff;

endmodule

`default_nettype wire

>>> rtl/ata_atan2.sv
// ----------------------------------------------------------------------------
// ata_atan2: pipelined atan2 in degrees
// Octant reduction, divider chain, cubic polynomial, quadrant fix, to degrees.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_atan2 #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int DEG_W           = ANGLE_FRAC_BITS + 10
) (
   input  wire logic                               clock,
   input  wire logic                               en,
   input  wire logic signed [ata_pkg::ARG_W-1:0]   in_y,
   input  wire logic signed [ata_pkg::ARG_W-1:0]   in_x,
   output logic signed      [DEG_W-1:0]            deg
);

   localparam int MAG_W  = ata_pkg::MAG_W;
   localparam int QUO_W  = ata_pkg::QUO_W;
   localparam int Z_W    = ata_pkg::Z_W;
   localparam int NSTEP  = ata_pkg::DIV_STEPS;
   localparam int ZM_W   = Z_W - 1;
   localparam int PROD_W = ZM_W + 22;
   localparam int SH     = 32 - ANGLE_FRAC_BITS;
   localparam logic [PROD_W:0] RND = (PROD_W+1)'(1) << (SH - 1);

   // quadrant codes
   localparam logic [1:0] QD_0 = 2'd0;
   localparam logic [1:0] QD_1 = 2'd1;
   localparam logic [1:0] QD_2 = 2'd2;
   localparam logic [1:0] QD_3 = 2'd3;

   typedef struct packed {
      logic [1:0] qc;
      logic       swap;
      logic       neg;
      logic       zero;
   } flag_type;

   // ---- octant reduction ----
   logic              y_neg, x_neg, y_nz, x_nz;
   logic [MAG_W-1:0]  y_mag, x_mag;
   logic signed [ata_pkg::ARG_W-1:0] y_abs, x_abs;
   flag_type          fl_in;
   logic [MAG_W-1:0]  num_in, den_in;

   always_comb begin
      y_neg = in_y[ata_pkg::ARG_W-1];
      x_neg = in_x[ata_pkg::ARG_W-1];
      y_abs = y_neg ? -in_y : in_y;
      x_abs = x_neg ? -in_x : in_x;
      y_mag = y_abs[MAG_W-1:0];
      x_mag = x_abs[MAG_W-1:0];
      y_nz  = (in_y != '0);
      x_nz  = (in_x != '0);
      fl_in.zero = !y_nz && !x_nz;
      fl_in.swap = (y_mag > x_mag);
      // higher quadrant codes win where the tests overlap
      if (!(y_neg || !y_nz) ? 1'b0 : !x_neg)
         fl_in.qc = QD_3;
      else if ((y_neg || !y_nz) && (x_neg || !x_nz))
         fl_in.qc = QD_2;
      else if (!y_neg && (x_neg || !x_nz))
         fl_in.qc = QD_1;
      else
         fl_in.qc = QD_0;
      fl_in.neg = fl_in.swap ? (x_neg != y_neg) : (y_neg != x_neg);
      num_in    = fl_in.swap ? x_mag : y_mag;
      den_in    = fl_in.swap ? y_mag : x_mag;
   end

   logic [MAG_W-1:0] a0_num_ff, a0_den_ff;
   flag_type         a0_flag_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         a0_num_ff  <= num_in;
         a0_den_ff  <= den_in;
         a0_flag_ff <= fl_in;
      end
   end

   // ---- divider chain: ratio = num * 2^16 / den ----
   logic [ata_pkg::DIV_REM_W-1:0] d_rem [NSTEP+1];
   logic [MAG_W-1:0]              d_den [NSTEP+1];
   logic [QUO_W-1:0]              d_quo [NSTEP+1];
   flag_type                      d_flag_ff [NSTEP];

   assign d_rem[0] = {{(ata_pkg::DIV_REM_W-MAG_W){1'b0}}, a0_num_ff};
   assign d_den[0] = a0_den_ff;
   assign d_quo[0] = '0;

   for (genvar k = 0; k < NSTEP; k++) begin : g_div
      ata_div_cell u_cell (
         .clock   (clock),
         .en      (en),
         .in_rem  (d_rem[k]),
         .in_den  (d_den[k]),
         .in_quo  (d_quo[k]),
         .out_rem (d_rem[k+1]),
         .out_den (d_den[k+1]),
         .out_quo (d_quo[k+1])
      );
   end

   // flags ride alongside the divider
   always_ff @(posedge clock) begin
      if (en) begin
         d_flag_ff[0] <= a0_flag_ff;
         for (int i = 1; i < NSTEP; i++) begin
            d_flag_ff[i] <= d_flag_ff[i-1];
         end
      end
   end

   // ---- polynomial ----
   localparam logic [12:0] C_K2_EXT = ata_pkg::C_K2;

   logic [QUO_W-1:0] a;
   assign a = d_quo[NSTEP];

   logic [29:0] p1_m1_ff;
   logic [33:0] p1_m2_ff;
   logic [32:0] p1_m3_ff, p2_m3_ff, p3_m3_ff;
   logic [14:0] p2_c_ff, p2_p_ff;
   logic [29:0] p3_pc_ff;
   logic [16:0] p4_f_ff;
   flag_type    p1_flag_ff, p2_flag_ff, p3_flag_ff, p4_flag_ff;
   logic [33:0] sum34;

   always_comb begin
      sum34 = {1'b0, p3_m3_ff} + {4'b0, p3_pc_ff};
   end

   always_ff @(posedge clock) begin
      if (en) begin
         // products
         p1_m1_ff   <= 30'(C_K2_EXT) * 30'(a);
         p1_m2_ff   <= 34'(a) * 34'(ata_pkg::Q_ONE - a);
         p1_m3_ff   <= 33'(ata_pkg::C_PI4) * 33'(a);
         p1_flag_ff <= d_flag_ff[NSTEP-1];
         // slope term and parabola
         p2_c_ff    <= 15'(ata_pkg::C_K1) + 15'(p1_m1_ff[29:16]);
         p2_p_ff    <= p1_m2_ff[30:16];
         p2_m3_ff   <= p1_m3_ff;
         p2_flag_ff <= p1_flag_ff;
         // p * c
         p3_pc_ff   <= 30'(p2_p_ff) * 30'(p2_c_ff);
         p3_m3_ff   <= p2_m3_ff;
         p3_flag_ff <= p2_flag_ff;
         // f = (PI4*a + p*c) >> 16
         p4_f_ff    <= sum34[32:16];
         p4_flag_ff <= p3_flag_ff;
      end
   end

   // ---- sign and quadrant correction ----
   logic signed [Z_W-1:0] fz, zs, z_in;

   always_comb begin
      fz = $signed(Z_W'(p4_f_ff));
      zs = p4_flag_ff.neg ? -fz : fz;
      if (p4_flag_ff.zero) begin
         z_in = '0;
      end else if (p4_flag_ff.swap) begin
         z_in = (p4_flag_ff.qc == QD_0 || p4_flag_ff.qc == QD_1)
                ? (ata_pkg::C_PI2 - zs) : (-ata_pkg::C_PI2 - zs);
      end else if (p4_flag_ff.qc == QD_1) begin
         z_in = ata_pkg::C_PI + zs;
      end else if (p4_flag_ff.qc == QD_2) begin
         z_in = -ata_pkg::C_PI + zs;
      end else begin
         z_in = zs;
      end
   end

   logic signed [Z_W-1:0] p5_z_ff;
   logic [ZM_W-1:0]       p6_zmag_ff;
   logic                  p6_zneg_ff, p7_zneg_ff;
   logic [PROD_W-1:0]     p7_prod_ff;
   logic signed [Z_W-1:0] zabs;

   // ---- radians to degrees, round half away from zero ----
   logic [PROD_W:0]       rsum;
   logic [DEG_W-2:0]      rmag;
   logic signed [DEG_W-1:0] deg_in, deg_ff;

   always_comb begin
      zabs   = p5_z_ff[Z_W-1] ? -p5_z_ff : p5_z_ff;
      rsum   = {1'b0, p7_prod_ff} + RND;
      rmag   = rsum[SH +: (DEG_W-1)];
      deg_in = p7_zneg_ff ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p5_z_ff    <= z_in;
         p6_zmag_ff <= zabs[ZM_W-1:0];
         p6_zneg_ff <= p5_z_ff[Z_W-1];
         p7_prod_ff <= PROD_W'(p6_zmag_ff) * PROD_W'(ata_pkg::C_RAD2DEG);
         p7_zneg_ff <= p6_zneg_ff;
         deg_ff     <= deg_in;
      end
   end

   assign deg = deg_ff;

endmodule

`default_nettype wire

>>> rtl/accel_tilt_angles.sv
// A sample passes offset, square, sum, root cell, atan2 and output registers.
// Throughput: one sample per cycle unless rsp is held; the pipeline advances as
// a whole, so a held result stalls every stage and req_ready drops only then.
// Most depth comes from the 25-cell square root and 17-cell divider chains.
// Reset clears the stage valid bits and the offset registers; no clearing pass.
// ----------------------------------------------------------------------------
// accel_tilt_angles: roll and pitch from a three-axis accelerometer sample
// Offset correction, squares, square root and atan2 cell chains, clamping.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_tilt_angles #(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int SAMPLE_WIDTH    = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire ata_pkg::req_type                     req_data,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output ata_pkg::rsp_type                          rsp_data,
   input  wire logic                                 csr_wen,
   input  wire logic [ata_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [15:0]                          csr_wdata
);

   localparam int AX_W     = ata_pkg::AX_W;
   localparam int NSQ      = ata_pkg::SQRT_STEPS;
   localparam int DEG_W    = ANGLE_FRAC_BITS + 10;
   localparam int FIN_W    = (ANGLE_FRAC_BITS + 11 > 17) ? ANGLE_FRAC_BITS + 11 : 17;
   localparam int PIPE_LAT = 3 + NSQ + ata_pkg::ATAN_LAT + 1;
   localparam logic signed [FIN_W-1:0] LIM   = FIN_W'(90 * (1 << ANGLE_FRAC_BITS));
   localparam logic signed [FIN_W-1:0] S_MAX = FIN_W'(32767);
   localparam logic signed [FIN_W-1:0] S_MIN = -FIN_W'(32768);

   typedef struct packed {
      logic signed [AX_W-1:0] ax;
      logic signed [AX_W-1:0] ay;
   } side_type;

   // ---- pipeline control ----
   logic                adv;
   logic [PIPE_LAT-1:0] vld_ff, vld_in;

   assign adv       = !vld_ff[PIPE_LAT-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[PIPE_LAT-1];
   assign vld_in    = {vld_ff[PIPE_LAT-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---- offset registers ----
   logic signed [15:0] off_x_ff, off_y_ff, off_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         off_x_ff <= '0;
         off_y_ff <= '0;
         off_z_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            ata_pkg::CSR_OFFSET_X: off_x_ff <= csr_wdata;
            ata_pkg::CSR_OFFSET_Y: off_y_ff <= csr_wdata;
            ata_pkg::CSR_OFFSET_Z: off_z_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---- stage 0: sign extend and add offsets ----
   logic [SAMPLE_WIDTH-1:0] raw_x, raw_y, raw_z;
   logic signed [AX_W-1:0]  ax_in, ay_in, az_in;
   logic signed [AX_W-1:0]  s0_ax_ff, s0_ay_ff, s0_az_ff;

   always_comb begin
      raw_x = req_data.accel_x[SAMPLE_WIDTH-1:0];
      raw_y = req_data.accel_y[SAMPLE_WIDTH-1:0];
      raw_z = req_data.accel_z[SAMPLE_WIDTH-1:0];
      ax_in = AX_W'($signed(raw_x)) + AX_W'(off_x_ff);
      ay_in = AX_W'($signed(raw_y)) + AX_W'(off_y_ff);
      az_in = AX_W'($signed(raw_z)) + AX_W'(off_z_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_ax_ff <= ax_in;
         s0_ay_ff <= ay_in;
         s0_az_ff <= az_in;
      end
   end

   // ---- stage 1: squares of magnitudes ----
   logic signed [AX_W-1:0] abs_x, abs_y, abs_z;
   logic [2*AX_W-2:0]      s1_sqx_ff, s1_sqy_ff, s1_sqz_ff;
   side_type               s1_side_ff;

   always_comb begin
      abs_x = s0_ax_ff[AX_W-1] ? -s0_ax_ff : s0_ax_ff;
      abs_y = s0_ay_ff[AX_W-1] ? -s0_ay_ff : s0_ay_ff;
      abs_z = s0_az_ff[AX_W-1] ? -s0_az_ff : s0_az_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_sqx_ff  <= (2*AX_W-1)'($unsigned(abs_x)) * (2*AX_W-1)'($unsigned(abs_x));
         s1_sqy_ff  <= (2*AX_W-1)'($unsigned(abs_y)) * (2*AX_W-1)'($unsigned(abs_y));
         s1_sqz_ff  <= (2*AX_W-1)'($unsigned(abs_z)) * (2*AX_W-1)'($unsigned(abs_z));
         s1_side_ff <= '{ax: s0_ax_ff, ay: s0_ay_ff};
      end
   end

   // ---- stage 2: sums, scaled into the radicand ----
   logic [ata_pkg::RAD_W-1:0] s2_yz_ff, s2_xz_ff;
   side_type                  s2_side_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_yz_ff   <= {ata_pkg::SQ_W'(s1_sqy_ff) + ata_pkg::SQ_W'(s1_sqz_ff), 16'b0};
         s2_xz_ff   <= {ata_pkg::SQ_W'(s1_sqx_ff) + ata_pkg::SQ_W'(s1_sqz_ff), 16'b0};
         s2_side_ff <= s1_side_ff;
      end
   end

   // ---- square root chains ----
   logic [ata_pkg::RAD_W-1:0]      yz_rad [NSQ+1], xz_rad [NSQ+1];
   logic [ata_pkg::SQRT_REM_W-1:0] yz_rem [NSQ+1], xz_rem [NSQ+1];
   logic [ata_pkg::ROOT_W-1:0]     yz_root [NSQ+1], xz_root [NSQ+1];
   side_type                       sq_side_ff [NSQ];

   assign yz_rad[0]  = s2_yz_ff;
   assign xz_rad[0]  = s2_xz_ff;
   assign yz_rem[0]  = '0;
   assign xz_rem[0]  = '0;
   assign yz_root[0] = '0;
   assign xz_root[0] = '0;

   for (genvar k = 0; k < NSQ; k++) begin : g_sqrt
      ata_sqrt_cell u_yz (
         .clock    (clock),
         .en       (adv),
         .in_rad   (yz_rad[k]),
         .in_rem   (yz_rem[k]),
         .in_root  (yz_root[k]),
         .out_rad  (yz_rad[k+1]),
         .out_rem  (yz_rem[k+1]),
         .out_root (yz_root[k+1])
      );
      ata_sqrt_cell u_xz (
         .clock    (clock),
         .en       (adv),
         .in_rad   (xz_rad[k]),
         .in_rem   (xz_rem[k]),
         .in_root  (xz_root[k]),
         .out_rad  (xz_rad[k+1]),
         .out_rem  (xz_rem[k+1]),
         .out_root (xz_root[k+1])
      );
   end

   // axis values ride alongside the roots
   always_ff @(posedge clock) begin
      if (adv) begin
         sq_side_ff[0] <= s2_side_ff;
         for (int i = 1; i < NSQ; i++) begin
            sq_side_ff[i] <= sq_side_ff[i-1];
         end
      end
   end

   // ---- atan2 units ----
   logic signed [ata_pkg::ARG_W-1:0] roll_y, roll_x, pitch_y, pitch_x;
   logic signed [DEG_W-1:0]          roll_deg, pitch_deg;

   always_comb begin
      roll_y  = ata_pkg::ARG_W'($signed({sq_side_ff[NSQ-1].ax, 8'b0}));
      roll_x  = $signed({1'b0, yz_root[NSQ]});
      pitch_y = $signed({1'b0, xz_root[NSQ]});
      pitch_x = ata_pkg::ARG_W'($signed({sq_side_ff[NSQ-1].ay, 8'b0}));
   end

   ata_atan2 #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DEG_W(DEG_W)) u_roll (
      .clock (clock),
      .en    (adv),
      .in_y  (roll_y),
      .in_x  (roll_x),
      .deg   (roll_deg)
   );

   ata_atan2 #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS), .DEG_W(DEG_W)) u_pitch (
      .clock (clock),
      .en    (adv),
      .in_y  (pitch_y),
      .in_x  (pitch_x),
      .deg   (pitch_deg)
   );

   // ---- clamp to +-90 degrees, then to 16 bits ----
   function automatic logic signed [15:0] clamp_angle(input logic signed [FIN_W-1:0] v);
      logic signed [FIN_W-1:0] t;
      t = v;
      if (t > LIM) t = LIM;
      if (t < -LIM) t = -LIM;
      if (t > S_MAX) t = S_MAX;
      if (t < S_MIN) t = S_MIN;
      return t[15:0];
   endfunction

   logic signed [FIN_W-1:0] roll_ext, pitch_ext;
   ata_pkg::rsp_type        rsp_ff, rsp_in;

   always_comb begin
      roll_ext           = FIN_W'(roll_deg);
      pitch_ext          = FIN_W'(pitch_deg) - LIM;
      rsp_in.roll_angle  = clamp_angle(roll_ext);
      rsp_in.pitch_angle = clamp_angle(pitch_ext);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

>>> rtl/ata_checker.sv
// ----------------------------------------------------------------------------
// ata_checker: port-level checks for accel_tilt_angles
// Flow control, reset and output range, bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ata_checker #(
   parameter int ANGLE_FRAC_BITS = 8
) (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ata_pkg::rsp_type rsp_data
);

   localparam int LIM_RAW = 90 * (1 << ANGLE_FRAC_BITS);
   localparam logic signed [15:0] LIM = (LIM_RAW > 32767) ? 16'sd32767 : 16'(LIM_RAW);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp payload changed while stalled");

   // input side stalls only when a result is held
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_ready == (!rsp_valid || rsp_ready))
      else $error("req_ready does not follow output stall");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid after reset");

   // angles in range
   a_roll_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.roll_angle <= LIM) && (rsp_data.roll_angle >= -LIM))
      else $error("roll out of range");

   a_pitch_rng: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.pitch_angle <= LIM) && (rsp_data.pitch_angle >= -LIM))
      else $error("pitch out of range");

endmodule

bind accel_tilt_angles ata_checker #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ata_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the accelerometer tilt angle pipeline
// Random and corner-case samples are sent through valid/ready with random
// gaps and back-pressure. Each result is compared against a fixed-point
// roll/pitch calculation done in the bench, under several offset settings.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

   localparam int FRAC_BITS  = 8;
   localparam int DRAIN_WAIT = 70;  // pipeline depth is 55

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   ata_pkg::req_type              req_data;
   logic                          rsp_valid;
   logic                          rsp_ready;
   ata_pkg::rsp_type              rsp_data;
   logic                          csr_wen;
   logic [ata_pkg::CSR_IDX_W-1:0] csr_index;
   logic [15:0]                   csr_wdata;

   accel_tilt_angles i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Bench copy of the offset registers
   logic signed [15:0] offs_x, offs_y, offs_z;

   ata_pkg::req_type samples_pending[$];
   ata_pkg::rsp_type angles_expected[$];
   logic    req_took;
   logic    idle_on;
   logic    hold_start, hold_done;
   int      hold_cnt;
   int      errors;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   // ---------------------------------------------------------------------
   // Fixed-point angle calculation
   // ---------------------------------------------------------------------
   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b >>= 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b >>= 2;
      end
      return r;
   endfunction

   function automatic longint abs_l(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // Cubic atan approximation on a Q16 ratio in [0, 1]
   function automatic longint atan_poly(longint a);
      longint c, p;
      c = 16037 + ((4345 * a) >>> 16);
      p = (a * (65536 - a)) >>> 16;
      return (51472 * a + p * c) >>> 16;
   endfunction

   // atan2 in radians Q16, octant reduction, last matching quadrant wins
   function automatic longint atan2_fix(longint y, longint x);
      longint my, mx, num, den, qm, z;
      bit     swap;
      int     quad;
      my = abs_l(y);
      mx = abs_l(x);
      if (my == 0 && mx == 0) return 0;
      swap = my > mx;
      quad = 0;
      if (y >= 0 && x <= 0) quad = 1;
      if (y <= 0 && x <= 0) quad = 2;
      if (y <= 0 && x >= 0) quad = 3;
      num = swap ? x : y;
      den = swap ? y : x;
      qm = (abs_l(num) << 16) / abs_l(den);
      if (qm > 65536) qm = 65536;
      z = atan_poly(qm);
      if ((num < 0) != (den < 0)) z = -z;
      if (swap) begin
         z = (quad <= 1) ? (102944 - z) : (-102944 - z);
      end else if (quad == 1) begin
         z = 205887 + z;
      end else if (quad == 2) begin
         z = -205887 + z;
      end
      return z;
   endfunction

   function automatic longint rad_to_deg(longint z);
      longint r;
      int     sh;
      sh = 32 - FRAC_BITS;
      r = (abs_l(z) * 3754937 + (64'sd1 <<< (sh - 1))) >>> sh;
      return (z < 0) ? -r : r;
   endfunction

   function automatic logic [15:0] clamp_angle(longint v);
      longint lim;
      lim = 90 * (1 << FRAC_BITS);
      if (v > lim) v = lim;
      if (v < -lim) v = -lim;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic ata_pkg::rsp_type tilt_angles(ata_pkg::req_type s);
      longint           ax, ay, az, r_yz, r_xz;
      ata_pkg::rsp_type t;
      ax = longint'(s.accel_x) + longint'(offs_x);
      ay = longint'(s.accel_y) + longint'(offs_y);
      az = longint'(s.accel_z) + longint'(offs_z);
      r_yz = longint'(int_sqrt((ay * ay + az * az) << 16));
      r_xz = longint'(int_sqrt((ax * ax + az * az) << 16));
      t.roll_angle  = clamp_angle(rad_to_deg(atan2_fix(ax * 256, r_yz)));
      t.pitch_angle = clamp_angle(rad_to_deg(atan2_fix(r_xz, ay * 256))
                                  - 90 * (1 << FRAC_BITS));
      return t;
   endfunction

   // ---------------------------------------------------------------------
   // Driver: next sample goes out once the previous transfer is done
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_took) begin
         if (samples_pending.size() > 0 && !(idle_on && $urandom_range(99) < 12)) begin
            req_valid <= 1'b1;
            req_data  <= samples_pending.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (hold_start && !hold_done) begin
         hold_cnt  <= 300;
         hold_done <= 1'b1;
         rsp_ready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt  <= hold_cnt - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= !(idle_on && $urandom_range(99) < 12);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predict on input transfer, compare on output transfer
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      ata_pkg::rsp_type want;
      req_took <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         angles_expected.push_back(tilt_angles(req_data));
      if (!reset && rsp_valid && rsp_ready) begin
         if (angles_expected.size() == 0) begin
            $display("%0t: unexpected result roll=%0d pitch=%0d", $time,
                     rsp_data.roll_angle, rsp_data.pitch_angle);
            errors++;
         end else begin
            want = angles_expected.pop_front();
            if (rsp_data.roll_angle !== want.roll_angle) begin
               $display("%0t: roll expected %0d actual %0d", $time,
                        want.roll_angle, rsp_data.roll_angle);
               errors++;
            end
            if (rsp_data.pitch_angle !== want.pitch_angle) begin
               $display("%0t: pitch expected %0d actual %0d", $time,
                        want.pitch_angle, rsp_data.pitch_angle);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   task automatic write_reg(logic [ata_pkg::CSR_IDX_W-1:0] idx, logic [15:0] val);
      @(negedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      if (idx == ata_pkg::CSR_OFFSET_X) offs_x = val;
      else if (idx == ata_pkg::CSR_OFFSET_Y) offs_y = val;
      else if (idx == ata_pkg::CSR_OFFSET_Z) offs_z = val;
      @(negedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_offsets(logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
      write_reg(ata_pkg::CSR_OFFSET_X, ox);
      write_reg(ata_pkg::CSR_OFFSET_Y, oy);
      write_reg(ata_pkg::CSR_OFFSET_Z, oz);
   endtask

   task automatic add_sample(logic [15:0] x, logic [15:0] y, logic [15:0] z);
      ata_pkg::req_type s;
      s.accel_x = x;
      s.accel_y = y;
      s.accel_z = z;
      samples_pending.push_back(s);
   endtask

   // Mostly full-range words, small ones, zero axes for octant edges, and extremes
   function automatic logic [15:0] rand_axis();
      int k;
      k = $urandom_range(9);
      if (k < 5) return 16'($urandom);
      if (k < 8) return 16'($signed($urandom_range(600)) - 300);
      if (k == 8) return 16'd0;
      return ($urandom_range(1) != 0) ? 16'h7fff : 16'h8000;
   endfunction

   task automatic add_random(int n);
      repeat (n) add_sample(rand_axis(), rand_axis(), rand_axis());
   endtask

   task automatic drain();
      wait (samples_pending.size() == 0 && !req_valid && angles_expected.size() == 0);
      repeat (DRAIN_WAIT) @(negedge clock);
   endtask

   initial begin
      errors     = 0;
      idle_on    = 1'b0;
      hold_start = 1'b0;
      hold_done  = 1'b0;
      hold_cnt   = 0;
      req_took   = 1'b0;
      rsp_ready  = 1'b0;
      req_valid  = 1'b0;
      req_data   = '0;
      csr_wen    = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      offs_x     = '0;
      offs_y     = '0;
      offs_z     = '0;
      reset      = 1'b1;
      repeat (4) @(negedge clock);
      reset = 1'b0;

      // Directed corners with reset offsets, then a random run, no idling
      add_sample(16'd0, 16'd0, 16'd0);          // zero vector
      add_sample(16'd0, 16'hff00, 16'd0);       // y only, negative: pitch saturates
      add_sample(16'd0, 16'd256, 16'd0);
      add_sample(16'd300, 16'd0, 16'd0);
      add_sample(16'hfed4, 16'd0, 16'd0);
      add_sample(16'd0, 16'd0, 16'd1000);
      add_sample(16'd0, 16'd0, 16'hfc18);
      add_sample(16'h7fff, 16'h7fff, 16'h7fff);
      add_sample(16'h8000, 16'h8000, 16'h8000);
      add_sample(16'h7fff, 16'h8000, 16'd0);
      add_sample(16'h8000, 16'h7fff, 16'h8000);
      add_sample(16'd500, 16'd500, 16'd0);      // equal magnitudes
      add_sample(16'hfe0c, 16'd500, 16'd0);
      add_sample(16'd500, 16'hfe0c, 16'd0);
      add_sample(16'd1, 16'd1, 16'd1);
      add_sample(16'hffff, 16'hffff, 16'hffff);
      add_sample(16'h5555, 16'haaaa, 16'h5555);
      add_sample(16'haaaa, 16'h5555, 16'haaaa);
      add_sample(16'd0, 16'h8000, 16'd0);
      add_random(50);
      drain();

      // Long receiver hold-off while samples keep coming
      idle_on    = 1'b1;
      hold_start = 1'b1;
      add_random(100);
      drain();

      // Unknown register index must be ignored
      write_reg(2'd3, 16'h1234);
      add_random(40);
      drain();

      // Extreme offsets: axis sums run past 16 bits; y offset alone hits -ay case
      set_offsets(16'h7fff, 16'h8000, 16'h7fff);
      add_sample(16'h7fff, 16'h8000, 16'h7fff);
      add_sample(16'h8001, 16'd0, 16'h8001);
      add_random(100);
      drain();

      set_offsets(16'h8000, 16'h7fff, 16'h8000);
      add_random(90);
      drain();

      set_offsets(16'd0, 16'hff00, 16'd0);
      add_sample(16'd0, 16'd0, 16'd0);
      add_random(40);
      drain();

      set_offsets(16'($urandom), 16'($urandom), 16'($urandom));
      add_random(100);
      drain();

      if (errors == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #2_000_000;
      $display("status: fail");
      $finish;
   end

endmodule

`default_nettype wire

>>> accel_tilt_angles.f
rtl/ata_pkg.sv
rtl/ata_sqrt_cell.sv
rtl/ata_div_cell.sv
rtl/ata_atan2.sv
rtl/accel_tilt_angles.sv
rtl/ata_checker.sv
tb/sv/tb.sv
